// ===== sv/qubit_state_vector_gate_engine_macros.svh =====
// Assertion macros used by the gate engine top level.
`ifndef QUBIT_STATE_VECTOR_GATE_ENGINE_MACROS_SVH
`define QUBIT_STATE_VECTOR_GATE_ENGINE_MACROS_SVH

// Same-cycle implication, checked on clk with rst_n as disable.
`define QSVGE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on clk with rst_n as disable.
`define QSVGE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/qsvge_pkg.sv =====
// Types and constants of the qubit state vector gate engine.
`default_nettype none
package qsvge_pkg;

    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 14;
    localparam int OUT_W     = 16;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_GATE   = 2'd1,
        OP_CGATE  = 2'd2,
        OP_READ   = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_RD_ISS,
        ST_RD_OUT,
        ST_G_RDI,
        ST_G_RDJ,
        ST_G_CAP,
        ST_G_CALC,
        ST_G_WRI,
        ST_G_WRJ
    } state_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] re;
        logic signed [COEF_W-1:0] im;
    } coef_t;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [2:0]               target_wire;
        logic [2:0]               control_wire;
        logic [5:0]               read_index;
        logic signed [COEF_W-1:0] m00_re;
        logic signed [COEF_W-1:0] m00_im;
        logic signed [COEF_W-1:0] m01_re;
        logic signed [COEF_W-1:0] m01_im;
        logic signed [COEF_W-1:0] m10_re;
        logic signed [COEF_W-1:0] m10_im;
        logic signed [COEF_W-1:0] m11_re;
        logic signed [COEF_W-1:0] m11_im;
    } cmd_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] amp_re;
        logic signed [OUT_W-1:0] amp_im;
        logic                    fault;
    } rsp_t;

endpackage
`default_nettype wire

// ===== sv/qsvge_stream_if.sv =====
// Valid/ready stream interface carrying one request or result.
`default_nettype none
interface qsvge_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/qsvge_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module qsvge_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/qubit_state_vector_gate_engine.sv =====
// Top level of the qubit state vector gate engine.
// Usage:
//   cmd (sink) takes one request: init, single gate, controlled gate or read.
//   result (source) returns one amplitude plus the sticky fault flag per read.
//   cfg_we/cfg_wdata write qubit_count; write it only while the block is idle.
// Operation:
//   Init sweeps the whole store, one entry a cycle.
//   A gate walks the 2^(n-1) index pairs one at a time through the single
//   RAM port pair: read i, read j, capture, five multiply/sum steps and two
//   write-backs per pair; a pair that the control skips ends at its first
//   read. The four-multiplier datapath and the one write port set this pace.
//   A read passes the issue and output states to reach the result register.
//   A bad wire only sets the fault flag and returns to idle without touching the store.
// Reset:
//   rst_n clears control state, the fault flag and sets qubit_count to 2.
//   The store is undefined until the first init; issue init first.
// Stall:
//   The result register holds while result.ready is low; gates and inits
//   proceed meanwhile, a further read waits until the result is taken.
`default_nettype none
`include "qubit_state_vector_gate_engine_macros.svh"
module qubit_state_vector_gate_engine
    import qsvge_pkg::*;
#(
    parameter int MAX_QUBITS = 6,
    parameter int AMP_WIDTH  = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_wdata,
    qsvge_stream_if.sink    cmd,
    qsvge_stream_if.source  result
);
    localparam int ADDR_W = MAX_QUBITS;
    localparam int DEPTH  = 1 << MAX_QUBITS;
    localparam int PW     = AMP_WIDTH + COEF_W;
    localparam int SW     = PW + 2;
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (AMP_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
    localparam logic signed [SW-1:0] ROUND  = SW'(64'sd1 <<< (COEF_FRAC - 1));
    localparam logic [AMP_WIDTH-1:0] AMP_ONE = AMP_WIDTH'(64'd1 << (AMP_WIDTH - 2));

    typedef logic signed [AMP_WIDTH-1:0] amp_t;

    state_t                  state_reg, state_next;
    logic [2:0]              qcount_reg;
    logic                    fault_reg, fault_next;
    logic [ADDR_W-1:0]       p_reg, p_next;
    logic [ADDR_W-1:0]       tbit_reg, tbit_next;
    logic [ADDR_W-1:0]       cbit_reg, cbit_next;
    logic                    ctl_reg, ctl_next;
    logic [ADDR_W-1:0]       idx_reg, idx_next;
    logic [ADDR_W-1:0]       last_reg, last_next;
    coef_t                   mat_reg [4];
    amp_t                    ar_reg, ai_reg, br_reg, bi_reg;
    logic [2:0]              k_reg;
    logic signed [PW-1:0]    prod_reg [4];
    amp_t                    res_reg [4];
    logic                    out_valid_reg;
    rsp_t                    out_reg;

    logic [3:0]              n_eff;
    logic [ADDR_W-1:0]       size_mask;
    logic [3:0]              tsh, csh;
    logic                    bad_wire;
    logic [ADDR_W+5:0]       ridx_ext;
    logic [ADDR_W-1:0]       low_mask, addr_i, addr_j;
    logic                    accept, pair_last, out_free;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [2*AMP_WIDTH-1:0]  ram_wdata, ram_rdata;

    logic [1:0]              k_lo;
    coef_t                   ma, mb;
    amp_t                    y0, y1, y2, y3;
    logic signed [PW-1:0]    p0, p1, p2, p3;
    logic signed [SW-1:0]    sum, rnd, shr;
    amp_t                    sat_val;
    logic                    sat_hit;
    logic signed [AMP_WIDTH+OUT_W-1:0] rd_re_ext, rd_im_ext;

    // Effective qubit count: zero acts as one, clamp at the store size.
    always_comb
    begin
        if (qcount_reg == 3'd0)
        begin
            n_eff = 4'd1;
        end
        else if (4'(qcount_reg) > 4'(MAX_QUBITS))
        begin
            n_eff = 4'(MAX_QUBITS);
        end
        else
        begin
            n_eff = 4'(qcount_reg);
        end
    end

    assign size_mask = {ADDR_W{1'b1}} >> (4'(ADDR_W) - n_eff);
    assign tsh       = n_eff - 4'd1 - {1'b0, cmd.data.target_wire};
    assign csh       = n_eff - 4'd1 - {1'b0, cmd.data.control_wire};
    assign ridx_ext  = {{ADDR_W{1'b0}}, cmd.data.read_index};

    always_comb
    begin
        bad_wire = ({1'b0, cmd.data.target_wire} >= n_eff);
        if (cmd.data.opcode == OP_CGATE)
        begin
            bad_wire = bad_wire || ({1'b0, cmd.data.control_wire} >= n_eff)
                || (cmd.data.control_wire == cmd.data.target_wire);
        end
    end

    // Pair index: insert a zero at the target bit of the pair counter.
    assign low_mask  = tbit_reg - ADDR_W'(1);
    assign addr_i    = ((p_reg & ~low_mask) << 1) | (p_reg & low_mask);
    assign addr_j    = addr_i | tbit_reg;
    assign pair_last = (p_reg == last_reg);
    assign out_free  = !out_valid_reg || result.ready;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.data.opcode)
                        OP_INIT:  state_next = ST_INIT;
                        OP_READ:  state_next = ST_RD_ISS;
                        default:  state_next = bad_wire ? ST_IDLE : ST_G_RDI;
                    endcase
                end
            end
            ST_INIT:   state_next = (p_reg == {ADDR_W{1'b1}}) ? ST_IDLE : ST_INIT;
            ST_RD_ISS: state_next = ST_RD_OUT;
            ST_RD_OUT: state_next = out_free ? ST_IDLE : ST_RD_OUT;
            ST_G_RDI:
            begin
                if (ctl_reg && ((addr_i & cbit_reg) == '0))
                begin
                    state_next = pair_last ? ST_IDLE : ST_G_RDI;
                end
                else
                begin
                    state_next = ST_G_RDJ;
                end
            end
            ST_G_RDJ:  state_next = ST_G_CAP;
            ST_G_CAP:  state_next = ST_G_CALC;
            ST_G_CALC: state_next = (k_reg == 3'd4) ? ST_G_WRI : ST_G_CALC;
            ST_G_WRI:  state_next = ST_G_WRJ;
            ST_G_WRJ:  state_next = pair_last ? ST_IDLE : ST_G_RDI;
            default:   state_next = ST_IDLE;
        endcase
    end

    // RAM control.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = p_reg;
        ram_wdata = '0;
        ram_raddr = idx_reg;
        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = (p_reg == '0) ? {AMP_ONE, {AMP_WIDTH{1'b0}}} : '0;
            end
            ST_G_RDI: ram_raddr = addr_i;
            ST_G_RDJ: ram_raddr = addr_j;
            ST_G_WRI:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_i;
                ram_wdata = {res_reg[0], res_reg[1]};
            end
            ST_G_WRJ:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_j;
                ram_wdata = {res_reg[2], res_reg[3]};
            end
            default:  ram_raddr = idx_reg;
        endcase
    end

    // Operand select: output k is row k[1], real part when k[0] is low.
    assign k_lo = k_reg[1:0];
    assign ma   = mat_reg[{k_lo[1], 1'b0}];
    assign mb   = mat_reg[{k_lo[1], 1'b1}];
    assign y0   = k_lo[0] ? ai_reg : ar_reg;
    assign y1   = k_lo[0] ? ar_reg : ai_reg;
    assign y2   = k_lo[0] ? bi_reg : br_reg;
    assign y3   = k_lo[0] ? br_reg : bi_reg;
    assign p0   = PW'(ma.re * y0);
    assign p1   = k_lo[0] ? PW'(ma.im * y1) : -PW'(ma.im * y1);
    assign p2   = PW'(mb.re * y2);
    assign p3   = k_lo[0] ? PW'(mb.im * y3) : -PW'(mb.im * y3);

    // Sum of the registered products, round half up, saturate.
    assign sum = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]) + SW'(prod_reg[3]);
    assign rnd = sum + ROUND;
    assign shr = rnd >>> COEF_FRAC;

    always_comb
    begin
        sat_hit = 1'b1;
        if (shr > SAT_HI)
        begin
            sat_val = SAT_HI[AMP_WIDTH-1:0];
        end
        else if (shr < SAT_LO)
        begin
            sat_val = SAT_LO[AMP_WIDTH-1:0];
        end
        else
        begin
            sat_val = shr[AMP_WIDTH-1:0];
            sat_hit = 1'b0;
        end
    end

    // Control and pointer next values.
    always_comb
    begin
        p_next     = p_reg;
        tbit_next  = tbit_reg;
        cbit_next  = cbit_reg;
        ctl_next   = ctl_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        fault_next = fault_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    p_next    = '0;
                    tbit_next = ADDR_W'(1) << tsh;
                    cbit_next = ADDR_W'(1) << csh;
                    ctl_next  = (cmd.data.opcode == OP_CGATE);
                    idx_next  = ridx_ext[ADDR_W-1:0] & size_mask;
                    last_next = size_mask >> 1;
                    if (cmd.data.opcode == OP_INIT)
                    begin
                        fault_next = 1'b0;
                    end
                    else if (cmd.data.opcode != OP_READ && bad_wire)
                    begin
                        fault_next = 1'b1;
                    end
                end
            end
            ST_INIT:  p_next = p_reg + ADDR_W'(1);
            ST_G_RDI:
            begin
                if (ctl_reg && ((addr_i & cbit_reg) == '0))
                begin
                    p_next = p_reg + ADDR_W'(1);
                end
            end
            ST_G_CALC:
            begin
                if (k_reg != 3'd0 && sat_hit)
                begin
                    fault_next = 1'b1;
                end
            end
            ST_G_WRJ: p_next = p_reg + ADDR_W'(1);
            default:  p_next = p_reg;
        endcase
    end

    assign rd_re_ext = (AMP_WIDTH+OUT_W)'(signed'(ram_rdata[2*AMP_WIDTH-1:AMP_WIDTH]));
    assign rd_im_ext = (AMP_WIDTH+OUT_W)'(signed'(ram_rdata[AMP_WIDTH-1:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            qcount_reg    <= 3'd2;
            fault_reg     <= 1'b0;
            p_reg         <= '0;
            k_reg         <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fault_reg <= fault_next;
            p_reg     <= p_next;
            if (cfg_we)
            begin
                qcount_reg <= cfg_wdata;
            end
            if (state_reg == ST_G_CALC)
            begin
                k_reg <= (k_reg == 3'd4) ? 3'd0 : k_reg + 3'd1;
            end
            // Drop the result once taken, load a new one when a read lands.
            if (state_reg == ST_RD_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        tbit_reg <= tbit_next;
        cbit_reg <= cbit_next;
        ctl_reg  <= ctl_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
        if (accept)
        begin
            mat_reg[0] <= '{re: cmd.data.m00_re, im: cmd.data.m00_im};
            mat_reg[1] <= '{re: cmd.data.m01_re, im: cmd.data.m01_im};
            mat_reg[2] <= '{re: cmd.data.m10_re, im: cmd.data.m10_im};
            mat_reg[3] <= '{re: cmd.data.m11_re, im: cmd.data.m11_im};
        end
        if (state_reg == ST_G_RDJ)
        begin
            ar_reg <= ram_rdata[2*AMP_WIDTH-1:AMP_WIDTH];
            ai_reg <= ram_rdata[AMP_WIDTH-1:0];
        end
        if (state_reg == ST_G_CAP)
        begin
            br_reg <= ram_rdata[2*AMP_WIDTH-1:AMP_WIDTH];
            bi_reg <= ram_rdata[AMP_WIDTH-1:0];
        end
        if (state_reg == ST_G_CALC)
        begin
            prod_reg[0] <= p0;
            prod_reg[1] <= p1;
            prod_reg[2] <= p2;
            prod_reg[3] <= p3;
            if (k_reg != 3'd0)
            begin
                res_reg[k_reg[1:0] - 2'd1] <= sat_val;
            end
        end
        if (state_reg == ST_RD_OUT && out_free)
        begin
            out_reg.amp_re <= rd_re_ext[OUT_W-1:0];
            out_reg.amp_im <= rd_im_ext[OUT_W-1:0];
            out_reg.fault  <= fault_reg;
        end
    end

    qsvge_ram #(
        .WIDTH (2 * AMP_WIDTH),
        .DEPTH (DEPTH)
    ) u_amp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    `QSVGE_ASSERT_NOW(a_we_states, ram_we, (state_reg == ST_INIT || state_reg == ST_G_WRI || state_reg == ST_G_WRJ))
    `QSVGE_ASSERT_NOW(a_j_has_tbit, state_reg == ST_G_WRJ, (ram_waddr & tbit_reg) != '0)
    `QSVGE_ASSERT_NEXT(a_init_ends, state_reg == ST_INIT && p_reg == {ADDR_W{1'b1}}, state_reg == ST_IDLE)
endmodule
`default_nettype wire

// ===== bench/qsvge_tb_pkg.sv =====
// Constants for the gate engine testbench checker.
`timescale 1ns / 1ps
package qsvge_tb_pkg;
    localparam int TB_MAX_QUBITS = 6;
    localparam int TB_DEPTH      = 1 << TB_MAX_QUBITS;
endpackage

// ===== bench/qsvge_tb_if.sv =====
// Bench-side note: the stream interface comes from the RTL; this file holds the config bundle.
`timescale 1ns / 1ps
interface qsvge_cfg_if;
    logic       we;
    logic [2:0] wdata;
    modport source (output we, output wdata);
    modport sink   (input we, input wdata);
endinterface

// ===== bench/qsvge_checker.sv =====
// Watches the request, result and config ports, predicts amplitudes and compares reads.
`timescale 1ns / 1ps
module qsvge_checker
    import qsvge_pkg::*;
    import qsvge_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        cmd_valid,
    input  logic        cmd_ready,
    input  cmd_t        cmd_data,
    input  logic        res_valid,
    input  logic        res_ready,
    input  rsp_t        res_data,
    output int          fail_count,
    output int          reads_pending
);
    logic signed [15:0] amp_re_q [TB_DEPTH];
    logic signed [15:0] amp_im_q [TB_DEPTH];
    logic               fault_q;
    logic [2:0]         qcount_q;
    rsp_t               expected_reads [$];

    function automatic int active_qubits();
        int n;
        n = qcount_q;
        if (n < 1) n = 1;
        if (n > TB_MAX_QUBITS) n = TB_MAX_QUBITS;
        return n;
    endfunction

    // round half up, floor shift by 14, saturate (sets fault)
    function automatic logic signed [15:0] round_sat(longint acc);
        longint r;
        r = (acc + 64'sd8192) >>> 14;
        if (r > 32767) begin fault_q = 1'b1; return 16'sh7fff; end
        if (r < -32768) begin fault_q = 1'b1; return 16'sh8000; end
        return r[15:0];
    endfunction

    task automatic apply_gate(cmd_t c);
        int n, size, tbit, cbit;
        bit ctl;
        longint ar, ai, br, bi;
        longint mr [4];
        longint mi [4];
        n = active_qubits();
        size = 1 << n;
        ctl = (c.opcode == OP_CGATE);
        if (c.target_wire >= n || (ctl && (c.control_wire >= n
                || c.control_wire == c.target_wire))) begin
            fault_q = 1'b1;
            return;
        end
        tbit = 1 << (n - 1 - c.target_wire);
        cbit = ctl ? 1 << (n - 1 - c.control_wire) : 0;
        mr[0] = c.m00_re; mi[0] = c.m00_im; mr[1] = c.m01_re; mi[1] = c.m01_im;
        mr[2] = c.m10_re; mi[2] = c.m10_im; mr[3] = c.m11_re; mi[3] = c.m11_im;
        for (int i = 0; i < size; i++) begin
            if ((i & tbit) != 0) continue;
            if (ctl && (i & cbit) == 0) continue;
            ar = amp_re_q[i]; ai = amp_im_q[i];
            br = amp_re_q[i | tbit]; bi = amp_im_q[i | tbit];
            amp_re_q[i] = round_sat(mr[0]*ar - mi[0]*ai + mr[1]*br - mi[1]*bi);
            amp_im_q[i] = round_sat(mr[0]*ai + mi[0]*ar + mr[1]*bi + mi[1]*br);
            amp_re_q[i | tbit] = round_sat(mr[2]*ar - mi[2]*ai + mr[3]*br - mi[3]*bi);
            amp_im_q[i | tbit] = round_sat(mr[2]*ai + mi[2]*ar + mr[3]*bi + mi[3]*br);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        rsp_t exp_r;
        int   idx;
        if (!rst_n) begin
            fault_q = 1'b0;
            qcount_q      <= 3'd2;
            fail_count    <= 0;
            reads_pending <= 0;
            expected_reads.delete();
        end else begin
            // retire a result first: it was computed by earlier requests
            if (res_valid && res_ready) begin
                if (expected_reads.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, res_data);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_reads.pop_front();
                    if (exp_r !== res_data) begin
                        $display("%0t: expected re=%0d im=%0d fault=%0b, %s",
                                 $time, exp_r.amp_re, exp_r.amp_im, exp_r.fault,
                                 $sformatf("actual re=%0d im=%0d fault=%0b",
                                 res_data.amp_re, res_data.amp_im, res_data.fault));
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_we) qcount_q <= cfg_wdata;
            if (cmd_valid && cmd_ready) begin
                case (cmd_data.opcode)
                    OP_INIT: begin
                        for (int i = 0; i < TB_DEPTH; i++) begin
                            amp_re_q[i] = 16'sd0;
                            amp_im_q[i] = 16'sd0;
                        end
                        amp_re_q[0] = 16'sd16384;
                        fault_q = 1'b0;
                    end
                    OP_READ: begin
                        idx = cmd_data.read_index & ((1 << active_qubits()) - 1);
                        exp_r.amp_re = amp_re_q[idx];
                        exp_r.amp_im = amp_im_q[idx];
                        exp_r.fault  = fault_q;
                        expected_reads.insert(expected_reads.size(), exp_r);
                    end
                    default: apply_gate(cmd_data);
                endcase
            end
            reads_pending <= expected_reads.size();
        end
    end
endmodule

// ===== bench/qubit_state_vector_gate_engine_tb.sv =====
// Testbench top: drives requests and config into the gate engine, reports the verdict.
`timescale 1ns / 1ps
module qubit_state_vector_gate_engine_tb;
    import qsvge_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   reads_pending;

    qsvge_cfg_if cfg_ch ();
    qsvge_stream_if #(.T(cmd_t)) cmd_ch ();
    qsvge_stream_if #(.T(rsp_t)) res_ch ();

    always #4 clk = ~clk;

    qubit_state_vector_gate_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_ch.we),
        .cfg_wdata (cfg_ch.wdata),
        .cmd       (cmd_ch),
        .result    (res_ch)
    );

    qsvge_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_ch.we),
        .cfg_wdata     (cfg_ch.wdata),
        .cmd_valid     (cmd_ch.valid),
        .cmd_ready     (cmd_ch.ready),
        .cmd_data      (cmd_ch.data),
        .res_valid     (res_ch.valid),
        .res_ready     (res_ch.ready),
        .res_data      (res_ch.data),
        .fail_count    (fail_count),
        .reads_pending (reads_pending)
    );

    // Start idle on every input so nothing is X at time zero.
    initial
    begin
        cfg_ch.we    = 1'b0;
        cfg_ch.wdata = 3'd0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        res_ch.ready = 1'b0;
    end

    // Result side: hold ready low for a random stretch, then raise it until a result leaves.
    // About one draw in three is forced to zero so there are runs with no backpressure.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            if (gap != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
        end
    end

    bit gappy;

    // Send one request, after an optional random gap, and wait for the handshake.
    // Valid stays high after the handshake; drop it before a gap or with end_requests.
    task automatic send_request(cmd_t c);
        int gap;
        gap = gappy ? $urandom_range(0, 11) : 0;
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.data  <= c;
        cmd_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
    endtask

    // Drop valid right after the last handshake.
    task automatic end_requests();
        cmd_ch.valid <= 1'b0;
    endtask

    // Random matrix entries; often near-unitary so the state stays alive,
    // sometimes full range to push saturation.
    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 65535));
            3: return 16'd11585;           // about 1/sqrt(2)
            4: return 16'd0;
            default: return 16'($urandom_range(0, 23170) - 11585);
        endcase
    endfunction

    function automatic cmd_t make_gate(logic [1:0] op, int n);
        cmd_t c;
        c = '0;
        c.opcode = op;
        // mostly legal wires, now and then a bad one (including full 3-bit range)
        if ($urandom_range(0, 9) == 0) begin
            c.target_wire  = 3'($urandom_range(0, 7));
            c.control_wire = 3'($urandom_range(0, 7));
        end else begin
            c.target_wire  = 3'($urandom_range(0, n - 1));
            c.control_wire = (n > 1)
                ? 3'((int'(c.target_wire) + int'($urandom_range(1, n - 1))) % n)
                : 3'($urandom_range(0, 7));
        end
        c.read_index = 6'($urandom_range(0, 63));
        c.m00_re = pick_coef(); c.m00_im = pick_coef();
        c.m01_re = pick_coef(); c.m01_im = pick_coef();
        c.m10_re = pick_coef(); c.m10_im = pick_coef();
        c.m11_re = pick_coef(); c.m11_im = pick_coef();
        return c;
    endfunction

    function automatic cmd_t make_read();
        cmd_t c;
        c = make_gate(OP_READ, 1);
        c.opcode = OP_READ;
        c.target_wire = 3'($urandom_range(0, 7));
        c.control_wire = 3'($urandom_range(0, 7));
        c.read_index = 6'($urandom_range(0, 63));
        return c;
    endfunction

    function automatic cmd_t make_init();
        cmd_t c;
        c = make_read();
        c.opcode = OP_INIT;
        return c;
    endfunction

    // Drain outstanding reads, then let any gate still sweeping finish before touching config.
    task automatic wait_idle();
        while (reads_pending != 0) @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic set_qubits(logic [2:0] q);
        cfg_ch.wdata <= q;
        cfg_ch.we    <= 1'b1;
        @(posedge clk);
        cfg_ch.we    <= 1'b0;
    endtask

    function automatic int eff_of(logic [2:0] q);
        if (q == 0) return 1;
        if (q > 6) return 6;
        return int'(q);
    endfunction

    initial
    begin
        cmd_t c;
        logic [2:0] qsel;
        int n;
        int sent;
        logic [2:0] qlist [8];
        qlist = '{3'd2, 3'd6, 3'd1, 3'd0, 3'd7, 3'd3, 3'd4, 3'd5};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset qubit count of 2, init, Hadamard-like, controlled X, saturation, bad wires, reads.
        gappy = 1'b0;
        n = 2;
        send_request(make_init());
        for (int i = 0; i < 4; i++)
        begin
            c = make_read(); c.read_index = 6'(i); send_request(c);
        end
        c = make_gate(OP_GATE, n); c.target_wire = 3'd0;
        c.m00_re = 16'sd11585; c.m01_re = 16'sd11585;
        c.m10_re = 16'sd11585; c.m11_re = -16'sd11585;
        c.m00_im = 16'sd0; c.m01_im = 16'sd0; c.m10_im = 16'sd0; c.m11_im = 16'sd0;
        send_request(c);
        c.opcode = OP_CGATE; c.target_wire = 3'd1; c.control_wire = 3'd0;
        c.m00_re = 16'sd0; c.m01_re = 16'sd16384; c.m10_re = 16'sd16384; c.m11_re = 16'sd0;
        send_request(c);
        c = make_read(); c.read_index = 6'h3f; send_request(c);
        // extreme matrix to saturate
        c = make_gate(OP_GATE, n); c.target_wire = 3'd1;
        c.m00_re = 16'sh7fff; c.m00_im = 16'sh7fff; c.m01_re = 16'sh8000; c.m01_im = 16'sh8000;
        c.m10_re = 16'sh8000; c.m10_im = 16'sh7fff; c.m11_re = 16'sh7fff; c.m11_im = 16'sh8000;
        send_request(c);
        c = make_read(); c.read_index = 6'd1; send_request(c);
        send_request(make_init());
        c = make_gate(OP_GATE, n); c.target_wire = 3'd7; send_request(c);
        c = make_read(); send_request(c);
        send_request(make_init());
        c = make_gate(OP_CGATE, n); c.target_wire = 3'd1; c.control_wire = 3'd1;
        send_request(c);
        c = make_read(); send_request(c);
        send_request(make_init());
        c = make_gate(OP_CGATE, n); c.target_wire = 3'd0; c.control_wire = 3'd5;
        send_request(c);
        c = make_read(); c.read_index = 6'd0; send_request(c);

        // Random phases across qubit counts, extremes and out-of-range codes included.
        sent = 0;
        for (int ph = 0; sent < 1200; ph++) begin
            end_requests();
            wait_idle();
            qsel = qlist[ph % 8];
            set_qubits(qsel);
            n = eff_of(qsel);
            gappy = (ph % 3) != 2;
            send_request(make_init());
            sent++;
            // large stores are slow: shorter phases there
            for (int k = 0; k < ((n >= 5) ? 30 : 120); k++) begin
                case ($urandom_range(0, 9))
                    0:       c = ($urandom_range(0, 3) == 0) ? make_init() : make_read();
                    1, 2, 3: c = make_gate(OP_GATE, n);
                    4, 5:    c = make_gate(OP_CGATE, n);
                    default: c = make_read();
                endcase
                send_request(c);
                sent++;
            end
        end

        end_requests();
        wait_idle();
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #40ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/qsvge_pkg.sv
sv/qsvge_stream_if.sv
sv/qsvge_ram.sv
sv/qubit_state_vector_gate_engine.sv
bench/qsvge_tb_pkg.sv
bench/qsvge_tb_if.sv
bench/qsvge_checker.sv
bench/qubit_state_vector_gate_engine_tb.sv
